// ===== design/ckf_pkg.sv =====
package ckf_pkg;

	localparam int PIX_W = 33;
	localparam logic [31:0] KEY_RESET = 32'hFFFF00FF;
	localparam logic [11:0] WIDTH_RESET = 12'd1;

	localparam logic REG_KEY   = 1'b0;
	localparam logic REG_WIDTH = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CALC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic advance;
		logic div_start;
	} cmd_t;

	typedef struct packed {
		logic has_result;
		logic div_done;
	} sts_t;

	// reciprocal of n in q16, used for the floored average of up to eight terms
	function automatic logic [16:0] recip(input logic [3:0] n);
		case (n)
			4'd1: recip = 17'd65536;
			4'd2: recip = 17'd32768;
			4'd3: recip = 17'd21846;
			4'd4: recip = 17'd16384;
			4'd5: recip = 17'd13108;
			4'd6: recip = 17'd10923;
			4'd7: recip = 17'd9363;
			4'd8: recip = 17'd8192;
			default: recip = 17'd0;
		endcase
	endfunction

endpackage

// ===== design/ckf_if.sv =====
interface ckf_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;
	modport source (output valid, op, red, green, blue, alpha, input ready);
	modport sink (input valid, op, red, green, blue, alpha, output ready);
endinterface

interface ckf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] out_alpha;
	logic       last_of_frame;
	modport source (output valid, out_red, out_green, out_blue, out_alpha, last_of_frame,
		input ready);
	modport sink (input valid, out_red, out_green, out_blue, out_alpha, last_of_frame,
		output ready);
endinterface

// ===== design/ckf_ctrl.sv =====
module ckf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ckf_pkg::sts_t sts,
	output ckf_pkg::cmd_t cmd
);
	import ckf_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.advance = 1'b1;
				state_d = ST_CALC;
			end
			ST_CALC: begin
				if (!sts.has_result) state_d = ST_IDLE;
				else begin
					cmd.div_start = 1'b1;
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				out_valid = sts.div_done;
				if (sts.div_done && out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_out_only_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == ST_OUT) else $error("output outside out state");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("accept while result pending");
	a_read_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> state_q == ST_READ) else $error("start not followed by read");
`endif
endmodule

// ===== design/ckf_datapath.sv =====
module ckf_datapath #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op,
	input  logic [7:0]    red,
	input  logic [7:0]    green,
	input  logic [7:0]    blue,
	input  logic [7:0]    alpha,
	input  logic [31:0]   key_color,
	input  logic [11:0]   frame_width,
	input  ckf_pkg::cmd_t cmd,
	output ckf_pkg::sts_t sts,
	output logic [7:0]    out_red,
	output logic [7:0]    out_green,
	output logic [7:0]    out_blue,
	output logic [7:0]    out_alpha,
	output logic          last_of_frame
);
	import ckf_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam logic [16:0] MAXW = 17'(MAX_WIDTH);

	pix_t upper_mem [MAX_WIDTH];
	pix_t middle_mem [MAX_WIDTH];
	pix_t up_rd_q, mid_rd_q, inc_q;
	pix_t win_q [9];
	logic [AW-1:0] col_q;
	logic [1:0]    rows_q;
	logic [11:0]   flush_q;
	logic          is_flush_q;
	logic [16:0]   w_eff;
	logic [16:0]   col_x;

	always_comb begin
		if (frame_width == 12'd0) w_eff = 17'd1;
		else if (17'(frame_width) > MAXW) w_eff = MAXW;
		else w_eff = 17'(frame_width);
	end
	assign col_x = 17'(col_q);

	// stage one: latch item, read line stores
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			up_rd_q <= upper_mem[col_q];
			mid_rd_q <= middle_mem[col_q];
			inc_q <= op ? '0 : {1'b1, alpha, red, green, blue};
			is_flush_q <= op;
		end
	end

	logic ending;
	logic [16:0] ccol;
	logic [11:0] flush_nx;
	assign flush_nx = is_flush_q ? ((flush_q == 12'hFFF) ? flush_q : flush_q + 12'd1) : 12'd0;
	assign ending = is_flush_q && (17'(flush_nx) >= w_eff + 17'd1);

	// edge info and ending, captured while advancing
	logic left_ok_q, right_ok_q, last_q;

	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			upper_mem[col_q] <= mid_rd_q;
			middle_mem[col_q] <= inc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
			col_q <= '0;
			rows_q <= '0;
			flush_q <= '0;
		end else if (cmd.advance) begin
			if (ending) begin
				for (int i = 0; i < 9; i++) win_q[i] <= '0;
				col_q <= '0;
				rows_q <= '0;
				flush_q <= '0;
			end else begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3] <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2] <= (rows_q >= 2'd2) ? up_rd_q : '0;
				win_q[5] <= (rows_q >= 2'd1) ? mid_rd_q : '0;
				win_q[8] <= inc_q;
				if (col_x + 17'd1 >= w_eff) begin
					col_q <= '0;
					if (rows_q < 2'd2) rows_q <= rows_q + 2'd1;
				end else col_q <= col_q + AW'(1);
				flush_q <= flush_nx;
			end
		end
	end

	assign ccol = (col_q == '0) ? w_eff - 17'd1 : col_x - 17'd1;

	// snapshot of window after shift, for the result calc
	pix_t sw_q [9];
	always_ff @(posedge clk) begin
		if (cmd.advance) begin
			for (int r = 0; r < 3; r++) begin
				sw_q[r*3] <= win_q[r*3+1];
				sw_q[r*3+1] <= win_q[r*3+2];
			end
			sw_q[2] <= (rows_q >= 2'd2) ? up_rd_q : '0;
			sw_q[5] <= (rows_q >= 2'd1) ? mid_rd_q : '0;
			sw_q[8] <= inc_q;
			left_ok_q <= ccol != 17'd0;
			right_ok_q <= ccol < w_eff - 17'd1;
			last_q <= ending;
		end
	end

	// neighbour sums
	logic [3:0]  n;
	logic [10:0] sr, sg, sb;
	logic        keyed;
	always_comb begin
		n = '0; sr = '0; sg = '0; sb = '0;
		for (int i = 0; i < 9; i++) begin
			if (i != 4 && !((i % 3 == 0) && !left_ok_q) && !((i % 3 == 2) && !right_ok_q)
				&& sw_q[i][32] && sw_q[i][31:0] != key_color && sw_q[i][31:24] != 8'd0) begin
				n = n + 4'd1;
				sr = sr + 11'(sw_q[i][23:16]);
				sg = sg + 11'(sw_q[i][15:8]);
				sb = sb + 11'(sw_q[i][7:0]);
			end
		end
	end
	assign keyed = sw_q[4][31:0] == key_color;
	assign sts.has_result = sw_q[4][32];

	// average by reciprocal multiply, then correction
	logic [10:0] sr_q, sg_q, sb_q;
	logic [3:0]  n_q;
	logic [27:0] pr_q, pg_q, pb_q;
	logic [1:0]  dcnt_q;
	logic        keyed_q;

	function automatic logic [7:0] fixq(input logic [27:0] p, input logic [10:0] s,
		input logic [3:0] d);
		logic [11:0] q;
		logic [15:0] prod;
		q = 12'(p >> 16);
		prod = 16'(q) * 16'(d);
		if (prod > 16'(s)) q = q - 12'd1;
		fixq = q[7:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dcnt_q <= '0;
		else if (cmd.div_start) dcnt_q <= 2'd1;
		else if (dcnt_q == 2'd1) dcnt_q <= 2'd2;
		else if (cmd.start) dcnt_q <= '0;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			sr_q <= sr; sg_q <= sg; sb_q <= sb; n_q <= n; keyed_q <= keyed;
		end
		if (dcnt_q == 2'd1) begin
			pr_q <= 28'(sr_q) * 28'(recip(n_q));
			pg_q <= 28'(sg_q) * 28'(recip(n_q));
			pb_q <= 28'(sb_q) * 28'(recip(n_q));
		end
	end
	assign sts.div_done = dcnt_q == 2'd2;

	always_comb begin
		if (!keyed_q) begin
			out_red = sw_q[4][23:16];
			out_green = sw_q[4][15:8];
			out_blue = sw_q[4][7:0];
			out_alpha = sw_q[4][31:24];
		end else begin
			out_alpha = 8'd0;
			if (n_q == 4'd0) begin
				out_red = '0; out_green = '0; out_blue = '0;
			end else begin
				out_red = fixq(pr_q, sr_q, n_q);
				out_green = fixq(pg_q, sg_q, n_q);
				out_blue = fixq(pb_q, sb_q, n_q);
			end
		end
	end
	assign last_of_frame = last_q;

`ifndef NO_ASSERTIONS
	a_rows_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q != 2'd3) else $error("rows counter overran");
	a_div_seq: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> dcnt_q == 2'd1) else $error("divider did not start");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_x < MAXW) else $error("column out of range");
`endif
endmodule

// ===== design/color_key_neighbor_fill_top.sv =====
// channel  | dir | handshake     | payload
// in_ch    | in  | valid/ready   | op, red, green, blue, alpha
// out_ch   | out | valid/ready   | out_red, out_green, out_blue, out_alpha, last_of_frame
// apb      | in  | psel/penable  | key_color at 0x0, frame_width at 0x4
//
// each item steps through a line-store read, a window shift and a neighbour sum; an
// item that gives output then forms the average by reciprocal multiply and waits
// for the output to be taken; a new item is taken only once the last one is done
// line stores need no clearing: rows_q gates every read
// arst_n clears controller, window and counters; registers return to reset values
// an unaccepted result holds the block; input ready drops until it leaves
module color_key_neighbor_fill_top #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	ckf_in_if.sink      in_ch,
	ckf_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ckf_pkg::*;

	logic [31:0] key_q;
	logic [11:0] width_q;
	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	// register file, written in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= KEY_RESET;
			width_q <= WIDTH_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_KEY: key_q <= pwdata;
				REG_WIDTH: width_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_KEY: prdata = key_q;
			REG_WIDTH: prdata = {20'd0, width_q};
			default: prdata = '0;
		endcase
	end

	ckf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	ckf_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.op(in_ch.op), .red(in_ch.red), .green(in_ch.green),
		.blue(in_ch.blue), .alpha(in_ch.alpha),
		.key_color(key_q), .frame_width(width_q),
		.cmd(cmd), .sts(sts),
		.out_red(out_ch.out_red), .out_green(out_ch.out_green),
		.out_blue(out_ch.out_blue), .out_alpha(out_ch.out_alpha),
		.last_of_frame(out_ch.last_of_frame)
	);
endmodule
